FILE: rtl/spqc_pkg.sv
package spqc_pkg;

  localparam int unsigned PulseW = 16;
  localparam int unsigned GainW  = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned AngleW = 8;
  localparam int unsigned QuadW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW  = CountW + GainW;

  localparam logic [PulseW-1:0] PulseHighRst = 16'd2000;
  localparam logic [PulseW-1:0] PulseLowRst  = 16'd1000;
  localparam logic [GainW-1:0]  GainRst      = 6'd11;
  localparam logic [CountW-1:0] CenterCount  = 7'd45;
  localparam logic [CountW-1:0] MaxCount     = 7'd90;
  localparam logic [AngleW-1:0] AngleMin     = 8'd45;
  localparam logic [AngleW-1:0] AngleMax     = 8'd135;
  localparam logic [QuadW-1:0]  QuadRst      = 2'd0;

  typedef enum logic [1:0] {
    FUNC_SET_ANGLE = 2'd0,
    FUNC_RAMP      = 2'd1,
    FUNC_ENCODER   = 2'd2,
    FUNC_CALIBRATE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_SPARE = 2'd3
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE_HIGH = 2'd0,
    REG_PULSE_LOW  = 2'd1,
    REG_GAIN       = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BWD  = 2'd2
  } quad_step_t;

  // Gray-code quadrature: forward order 0 -> 2 -> 3 -> 1 -> 0
  function automatic quad_step_t quad_step(input logic [QuadW-1:0] prev,
                                           input logic [QuadW-1:0] now);
    logic [QuadW-1:0] fwd;
    logic [QuadW-1:0] bwd;
    case (prev)
      2'd0: begin fwd = 2'd2; bwd = 2'd1; end
      2'd1: begin fwd = 2'd0; bwd = 2'd3; end
      2'd2: begin fwd = 2'd3; bwd = 2'd0; end
      default: begin fwd = 2'd1; bwd = 2'd2; end
    endcase
    if (now == fwd) return STEP_FWD;
    if (now == bwd) return STEP_BWD;
    return STEP_NONE;
  endfunction

endpackage

FILE: rtl/servo_pulse_quadrature_controller.sv
// Servo pulse compare controller with quadrature encoder input.
// Input channel: in_valid/in_stall carry one event beat (in_func, in_angle,
// in_direction, in_quad). Set angle loads pulse_high - (angle-45)*gain for
// 45..135 degrees, ramp moves the compare value one count toward a limit,
// encoder samples step a 0..90 position count, calibrate recenters it.
// Result channel: out_valid/out_stall carry the compare value and position
// after each event, exactly one result beat per event.
// The result shows on the output register in the cycle after the event is taken.
// One event per cycle is sustained while the output is not stalled; the state
// update (one 7x6 multiply, subtract and clamp) is combinational.
// A stalled result holds in the output register; while it is full and stalled,
// in_stall is raised, otherwise a new event is taken in the same cycle that
// the previous result leaves.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 pulse_high, 1 pulse_low, 2 counts_per_degree); write only when idle.
// Reset (rst_n low, synchronous) restores the registers to 2000/1000/11,
// the compare value to 2000, the position to 45 and empties the output.
module servo_pulse_quadrature_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spqc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [spqc_pkg::PulseW-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [spqc_pkg::AngleW-1:0]     in_angle,
  input  logic [1:0]                      in_direction,
  input  logic [spqc_pkg::QuadW-1:0]      in_quad,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spqc_pkg::PulseW-1:0]     out_compare_value,
  output logic [spqc_pkg::CountW-1:0]     out_encoder_count
);

  logic [spqc_pkg::PulseW-1:0] pulse_high_r;
  logic [spqc_pkg::PulseW-1:0] pulse_low_r;
  logic [spqc_pkg::GainW-1:0]  gain_r;

  logic [spqc_pkg::PulseW-1:0] compare_r, compare_nxt;
  logic [spqc_pkg::QuadW-1:0]  quad_last_r, quad_last_nxt;
  logic [spqc_pkg::CountW-1:0] position_r, position_nxt;
  logic                        out_valid_r;

  logic                        in_accept;
  spqc_pkg::func_t             func;
  spqc_pkg::dir_t              dir;
  spqc_pkg::quad_step_t        step;
  logic [spqc_pkg::CountW-1:0] offset;
  logic [spqc_pkg::ProdW-1:0]  product;
  logic [spqc_pkg::PulseW-1:0] loaded;
  logic                        angle_ok;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_compare_value = compare_r;
  assign out_encoder_count = position_r;

  assign func = spqc_pkg::func_t'(in_func);
  assign dir  = spqc_pkg::dir_t'(in_direction);
  assign step = spqc_pkg::quad_step(quad_last_r, in_quad);
  assign angle_ok = (in_angle >= spqc_pkg::AngleMin) && (in_angle <= spqc_pkg::AngleMax);

  always_comb begin
    // advance the encoder count, clamped to 0..MaxCount
    position_nxt = position_r;
    case (step)
      spqc_pkg::STEP_FWD: begin
        if (position_r != spqc_pkg::MaxCount) position_nxt = position_r + 7'd1;
      end
      spqc_pkg::STEP_BWD: begin
        if (position_r != '0) position_nxt = position_r - 7'd1;
      end
      default: position_nxt = position_r;
    endcase
    if (func == spqc_pkg::FUNC_CALIBRATE) position_nxt = spqc_pkg::CenterCount;
  end

  always_comb begin
    case (func)
      spqc_pkg::FUNC_SET_ANGLE: offset = spqc_pkg::CountW'(in_angle - spqc_pkg::AngleMin);
      spqc_pkg::FUNC_ENCODER:   offset = position_nxt;
      default:                  offset = spqc_pkg::CenterCount;
    endcase
    product = spqc_pkg::ProdW'(offset) * spqc_pkg::ProdW'(gain_r);
    // saturate at zero when the product exceeds pulse_high
    if ({{(spqc_pkg::PulseW-spqc_pkg::ProdW){1'b0}}, product} > pulse_high_r) begin
      loaded = '0;
    end else begin
      loaded = pulse_high_r - {{(spqc_pkg::PulseW-spqc_pkg::ProdW){1'b0}}, product};
    end
  end

  always_comb begin
    compare_nxt   = compare_r;
    quad_last_nxt = quad_last_r;
    case (func)
      spqc_pkg::FUNC_SET_ANGLE: begin
        if (angle_ok) compare_nxt = loaded;
      end
      spqc_pkg::FUNC_RAMP: begin
        if (dir == spqc_pkg::DIR_UP && compare_r < pulse_high_r) begin
          compare_nxt = compare_r + 16'd1;
        end else if (dir == spqc_pkg::DIR_DOWN && compare_r > pulse_low_r) begin
          compare_nxt = compare_r - 16'd1;
        end
      end
      spqc_pkg::FUNC_ENCODER: begin
        // unchanged pins: no reload
        if (in_quad != quad_last_r) begin
          quad_last_nxt = in_quad;
          compare_nxt   = loaded;
        end
      end
      default: compare_nxt = loaded;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_high_r <= spqc_pkg::PulseHighRst;
      pulse_low_r  <= spqc_pkg::PulseLowRst;
      gain_r       <= spqc_pkg::GainRst;
    end else if (cfg_we) begin
      case (spqc_pkg::cfg_reg_t'(cfg_index))
        spqc_pkg::REG_PULSE_HIGH: pulse_high_r <= cfg_data;
        spqc_pkg::REG_PULSE_LOW:  pulse_low_r  <= cfg_data;
        spqc_pkg::REG_GAIN:       gain_r       <= cfg_data[spqc_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r   <= spqc_pkg::PulseHighRst;
      quad_last_r <= spqc_pkg::QuadRst;
      position_r  <= spqc_pkg::CenterCount;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      compare_r   <= compare_nxt;
      quad_last_r <= quad_last_nxt;
      if (func == spqc_pkg::FUNC_CALIBRATE ||
          (func == spqc_pkg::FUNC_ENCODER && in_quad != quad_last_r)) begin
        position_r <= position_nxt;
      end
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // drop the beat once taken
      out_valid_r <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= spqc_pkg::MaxCount)
    else $error("encoder count out of range");

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted event produced no result beat");

  a_calibrate: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && func == spqc_pkg::FUNC_CALIBRATE |=>
      out_encoder_count == spqc_pkg::CenterCount)
    else $error("calibrate did not recenter the count");

  a_ramp_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && func == spqc_pkg::FUNC_RAMP && dir == spqc_pkg::DIR_UP &&
      compare_r < pulse_high_r |=> compare_r == $past(compare_r) + 16'd1)
    else $error("ramp up did not advance by one count");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept && !cfg_we |=> $stable(compare_r) && $stable(position_r))
    else $error("state changed without an event");
`endif

endmodule

FILE: tb/servo_pulse_quadrature_controller_test.sv
`timescale 1ns / 1ps

module servo_pulse_quadrature_controller_test;
  import spqc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax = 10;

  // forward Gray order 0 -> 2 -> 3 -> 1 -> 0
  localparam logic [QuadW-1:0] FwdNext [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [QuadW-1:0] BwdNext [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  typedef struct packed {
    logic [PulseW-1:0] compare;
    logic [CountW-1:0] count;
  } servo_reading_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [PulseW-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = '0;
  logic [AngleW-1:0]  in_angle = '0;
  logic [1:0]         in_direction = '0;
  logic [QuadW-1:0]   in_quad = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PulseW-1:0]  out_compare_value;
  logic [CountW-1:0]  out_encoder_count;

  // predicted block state and register copies
  logic [PulseW-1:0] set_high = PulseHighRst;
  logic [PulseW-1:0] set_low = PulseLowRst;
  logic [GainW-1:0]  set_gain = GainRst;
  logic [PulseW-1:0] servo_cmp = PulseHighRst;
  logic [QuadW-1:0]  enc_pins = QuadRst;
  logic [CountW-1:0] enc_position = CenterCount;

  servo_reading_t pending_readings[$];
  servo_reading_t want;

  int gap_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int error_count = 0;
  int events_sent = 0;
  int results_seen = 0;
  int settings_count = 0;
  int clamp_low_hits = 0;
  int clamp_high_hits = 0;
  int saturated_loads = 0;

  servo_pulse_quadrature_controller DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_angle         (in_angle),
    .in_direction     (in_direction),
    .in_quad          (in_quad),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_compare_value(out_compare_value),
    .out_encoder_count(out_encoder_count)
  );

  always #6 clk = ~clk;

  function automatic logic [PulseW-1:0] compare_for(input logic [CountW-1:0] offset);
    logic [ProdW-1:0] sub;
    sub = ProdW'(offset) * ProdW'(set_gain);
    if (PulseW'(sub) > set_high) begin
      saturated_loads++;
      return '0;
    end
    return set_high - PulseW'(sub);
  endfunction

  function automatic void advance_servo(input func_t f, input logic [AngleW-1:0] ang,
                                        input logic [1:0] dir, input logic [QuadW-1:0] pins);
    int pos;
    servo_reading_t r;
    case (f)
      FUNC_SET_ANGLE: begin
        if (ang >= AngleMin && ang <= AngleMax)
          servo_cmp = compare_for(CountW'(ang - AngleMin));
      end
      FUNC_RAMP: begin
        if (dir == DIR_UP && servo_cmp < set_high)
          servo_cmp = servo_cmp + 16'd1;
        else if (dir == DIR_DOWN && servo_cmp > set_low)
          servo_cmp = servo_cmp - 16'd1;
      end
      FUNC_ENCODER: begin
        if (pins != enc_pins) begin
          pos = int'(enc_position);
          if (pins == FwdNext[enc_pins])
            pos++;
          else if (pins == BwdNext[enc_pins])
            pos--;
          enc_pins = pins;
          if (pos < 0) begin
            pos = 0;
            clamp_low_hits++;
          end
          if (pos > int'(MaxCount)) begin
            pos = int'(MaxCount);
            clamp_high_hits++;
          end
          enc_position = CountW'(pos);
          servo_cmp = compare_for(enc_position);
        end
      end
      default: begin
        enc_position = CenterCount;
        servo_cmp = compare_for(CenterCount);
      end
    endcase
    r.compare = servo_cmp;
    r.count = enc_position;
    pending_readings.push_back(r);
  endfunction

  task automatic send_event(input func_t f, input logic [AngleW-1:0] ang,
                            input logic [1:0] dir, input logic [QuadW-1:0] pins);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_angle <= ang;
    in_direction <= dir;
    in_quad <= pins;
    do @(posedge clk); while (in_stall);
    advance_servo(f, ang, dir, pins);
    events_sent++;
  endtask

  // drop valid and let every pending result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [PulseW-1:0] high, input logic [PulseW-1:0] low,
                                input logic [PulseW-1:0] gain);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_PULSE_HIGH;
    cfg_data <= high;
    @(posedge clk);
    cfg_index <= REG_PULSE_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= REG_GAIN;
    cfg_data <= gain;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_high = high;
    set_low = low;
    set_gain = gain[GainW-1:0];
    settings_count++;
  endtask

  task automatic random_events(input int n);
    int sent;
    int kind;
    int len;
    int roll;
    logic heading;
    logic [1:0] dir;
    logic [QuadW-1:0] pins;
    logic [AngleW-1:0] ang;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // mostly one-way walk so the count reaches both clamps
        len = $urandom_range(5, 60);
        heading = 1'($urandom_range(0, 1));
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 85)
            pins = heading ? FwdNext[enc_pins] : BwdNext[enc_pins];
          else if (roll < 93)
            pins = heading ? BwdNext[enc_pins] : FwdNext[enc_pins];
          else if (roll < 97)
            pins = enc_pins;
          else
            pins = ~enc_pins;
          send_event(FUNC_ENCODER, AngleW'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), pins);
          sent++;
        end
      end else if (kind < 65) begin
        roll = $urandom_range(0, 99);
        if (roll < 45)
          dir = DIR_UP;
        else if (roll < 90)
          dir = DIR_DOWN;
        else if (roll < 95)
          dir = DIR_NONE;
        else
          dir = DIR_SPARE;
        len = $urandom_range(1, 40);
        repeat (len) begin
          send_event(FUNC_RAMP, AngleW'($urandom_range(0, 255)), dir,
                     QuadW'($urandom_range(0, 3)));
          sent++;
        end
      end else if (kind < 85) begin
        if ($urandom_range(0, 99) < 80)
          ang = AngleW'($urandom_range(AngleMin, AngleMax));
        else
          ang = AngleW'($urandom_range(0, 255));
        send_event(FUNC_SET_ANGLE, ang, 2'($urandom_range(0, 3)),
                   QuadW'($urandom_range(0, 3)));
        sent++;
      end else if (kind < 92) begin
        send_event(FUNC_CALIBRATE, AngleW'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)), QuadW'($urandom_range(0, 3)));
        sent++;
      end else begin
        send_event(func_t'($urandom_range(0, 3)), AngleW'($urandom_range(0, 255)),
                   2'($urandom_range(0, 3)), QuadW'($urandom_range(0, 3)));
        sent++;
      end
    end
  endtask

  task automatic test_directed_events();
    gap_pct = 0;
    stall_pct = 0;
    send_event(FUNC_SET_ANGLE, AngleMin, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, AngleMax, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd44, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd136, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd0, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd255, DIR_NONE, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_UP, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_DOWN, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_NONE, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_SPARE, 2'd0);
    // unchanged pins, a full forward turn, one step back, then a two-state jump
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd0);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd2);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd3);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd1);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd0);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd1);
    send_event(FUNC_ENCODER, 8'd0, DIR_NONE, 2'd2);
    send_event(FUNC_CALIBRATE, 8'd255, DIR_SPARE, 2'd3);
  endtask

  task automatic test_limits_and_saturation();
    apply_settings(16'd100, 16'hFFFF, 16'd63);
    send_event(FUNC_SET_ANGLE, AngleMax, DIR_NONE, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd46, DIR_NONE, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_DOWN, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_UP, 2'd0);
    // compare value now sits above the upper limit
    apply_settings(16'd0, 16'd0, 16'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_UP, 2'd0);
    send_event(FUNC_RAMP, 8'd0, DIR_DOWN, 2'd0);
    send_event(FUNC_SET_ANGLE, 8'd100, DIR_NONE, 2'd0);
  endtask

  task automatic test_random_default_gain();
    apply_settings(PulseHighRst, PulseLowRst, 16'(GainRst));
    gap_pct = 15;
    stall_pct = 10;
    random_events(360);
  endtask

  task automatic test_random_extreme_range();
    apply_settings(16'hFFFF, 16'd0, 16'hFFFF);
    gap_pct = 35;
    stall_pct = 25;
    random_events(360);
  endtask

  task automatic test_random_narrow_ramp();
    logic [PulseW-1:0] high;
    high = 16'($urandom_range(200, 60000));
    apply_settings(high, high - 16'($urandom_range(0, 30)), 16'($urandom_range(1, 62)));
    gap_pct = 5;
    stall_pct = 5;
    random_events(360);
  endtask

  task automatic test_random_inverted_limits();
    apply_settings(16'($urandom_range(0, 600)), 16'hFFFF, 16'($urandom_range(32, 63)));
    gap_pct = 20;
    stall_pct = 40;
    random_events(360);
  endtask

  task automatic test_random_back_to_back();
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
    gap_pct = 0;
    stall_pct = 0;
    random_events(360);
  endtask

  always begin
    @(posedge clk);
    if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic void report_mismatch(input string what, input servo_reading_t exp_r,
                                          input servo_reading_t act_r);
    error_count++;
    if (error_count <= ReportMax)
      $display("%0t: %s: expected compare %0d count %0d, got compare %0d count %0d",
               $realtime, what, exp_r.compare, exp_r.count, act_r.compare, act_r.count);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("result beat with nothing pending", '0,
                        {out_compare_value, out_encoder_count});
      end else begin
        want = pending_readings.pop_front();
        if (out_compare_value !== want.compare || out_encoder_count !== want.count)
          report_mismatch("result mismatch", want, {out_compare_value, out_encoder_count});
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_readings.size());
    $display("FAIL servo_pulse_quadrature_controller");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_limits_and_saturation();
    test_random_default_gain();
    test_random_extreme_range();
    test_random_narrow_ramp();
    test_random_inverted_limits();
    test_random_back_to_back();
    settle();
    repeat (4) @(posedge clk);
    if (pending_readings.size() != 0)
      error_count++;
    $display("Sent %0d events, checked %0d results across %0d register settings.",
             events_sent, results_seen, settings_count);
    $display("Encoder clamped at 0 %0d times and at 90 %0d times; %0d loads saturated to 0.",
             clamp_low_hits, clamp_high_hits, saturated_loads);
    if (error_count == 0)
      $display("PASS servo_pulse_quadrature_controller");
    else
      $display("FAIL servo_pulse_quadrature_controller");
    $finish;
  end

endmodule

FILE: sim.f
rtl/spqc_pkg.sv
rtl/servo_pulse_quadrature_controller.sv
tb/servo_pulse_quadrature_controller_test.sv
